### design/css_pkg.sv
// Shared types and constants for the cocktail shaker sorter.
// Holds the item and result structs and the compare-exchange result type.
// No dependencies.
package css_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef struct packed {
		logic signed [VAL_W-1:0] element_value;
		logic                    final_element;
	} css_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] sorted_value;
		logic                    final_result;
		logic                    overflow_seen;
	} css_result_t;

	typedef struct packed {
		logic                    gt;
		logic signed [VAL_W-1:0] lo_val;
		logic signed [VAL_W-1:0] hi_val;
	} css_cmp_t;

endpackage

### design/css_cmp_swap.sv
// Compare-exchange unit of the cocktail shaker sorter.
// Orders one pair of signed values; depends on css_pkg.
module css_cmp_swap (
	input  logic signed [css_pkg::VAL_W-1:0] a,
	input  logic signed [css_pkg::VAL_W-1:0] b,
	output css_pkg::css_cmp_t                res
);
	import css_pkg::*;

	// Swap only on strict greater, so equal values keep their places.
	always_comb begin
		res.gt = (a > b);
		if (res.gt) begin
			res.lo_val = b;
			res.hi_val = a;
		end else begin
			res.lo_val = a;
			res.hi_val = b;
		end
	end

endmodule

### design/cocktail_shaker_sorter.sv
// Cocktail shaker sorter top level: value store, pass sequencer and result register.
// Depends on css_pkg and css_cmp_swap.
//
// Values are taken one item per cycle while the block is idle and written into a
// store of CAPACITY entries; an item arriving with the store full is dropped and
// the set is flagged as overflowed. The item marked final closes the set (and is
// itself stored if there is room). item_stall then stays high until every sorted
// value has been delivered. The sort runs alternating forward and backward passes
// through one compare-exchange unit against the single-write-port store. Results
// then leave one at a time after a lead-in read, one store read each and each held
// until taken, the last one carrying final_result and every one carrying
// overflow_seen when values were dropped. The store holds no reset state; only
// entries below the fill count are ever read.
module cocktail_shaker_sorter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  css_pkg::css_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output css_pkg::css_result_t result
);
	import css_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_F_INIT = 10'b00_0000_0010,
		ST_F_LOAD = 10'b00_0000_0100,
		ST_F_STEP = 10'b00_0000_1000,
		ST_F_END  = 10'b00_0001_0000,
		ST_B_STEP = 10'b00_0010_0000,
		ST_B_END  = 10'b00_0100_0000,
		ST_E_RD   = 10'b00_1000_0000,
		ST_E_LD   = 10'b01_0000_0000,
		ST_E_WAIT = 10'b10_0000_0000
	} css_state_t;

	css_state_t state_q, state_d;

	// Fill count and overflow mark of the set being collected.
	logic [CNT_W-1:0] count_q, count_d;
	logic             ovf_q, ovf_d;

	// Pass bounds, walking index and output index.
	logic [IDX_W-1:0] lo_q, lo_d;
	logic [IDX_W-1:0] hi_q, hi_d;
	logic [IDX_W-1:0] i_q, i_d;
	logic [IDX_W-1:0] k_q, k_d;

	// carry_q travels with the pass; edge_q is the last value written by a compare step, which
	// seeds the carry of the next pass in the other direction.
	logic signed [VAL_W-1:0] carry_q, carry_d;
	logic signed [VAL_W-1:0] edge_q, edge_d;
	logic                    swapped_q, swapped_d;

	css_result_t out_q, out_d;
	logic        out_valid_q, out_valid_d;

	// Store: one write port, one registered read port.
	logic signed [VAL_W-1:0] store_q [CAPACITY];
	logic signed [VAL_W-1:0] rd_data_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic signed [VAL_W-1:0] wr_data;

	// Shared compare-exchange unit.
	logic signed [VAL_W-1:0] cmp_a, cmp_b;
	css_cmp_t                cmp_res;

	css_cmp_swap u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Forward pass bubbles the running maximum up; backward pass carries the minimum down.
	always_comb begin
		cmp_a = carry_q;
		cmp_b = rd_data_q;
		if (state_q == ST_B_STEP) begin
			cmp_a = rd_data_q;
			cmp_b = carry_q;
		end
	end

	always_comb begin
		logic [CNT_W-1:0] n_new;
		logic [IDX_W-1:0] i_next;
		logic [IDX_W-1:0] hi_new;
		logic [IDX_W-1:0] lo_new;

		state_d     = state_q;
		count_d     = count_q;
		ovf_d       = ovf_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		i_d         = i_q;
		k_d         = k_q;
		carry_d     = carry_q;
		edge_d      = edge_q;
		swapped_d   = swapped_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = item.element_value;
		n_new       = count_q;
		i_next      = i_q;
		hi_new      = hi_q;
		lo_new      = lo_q;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (count_q < CNT_W'(CAPACITY)) begin
						wr_en   = 1'b1;
						wr_addr = count_q[IDX_W-1:0];
						n_new   = count_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					count_d = n_new;
					if (item.final_element) begin
						k_d = '0;
						if (n_new < CNT_W'(2)) begin
							state_d = ST_E_RD;
						end else begin
							lo_d    = '0;
							hi_d    = IDX_W'(n_new - CNT_W'(1));
							state_d = ST_F_INIT;
						end
					end
				end
			end
			ST_F_INIT: begin
				rd_addr = lo_q;
				state_d = ST_F_LOAD;
			end
			ST_F_LOAD: begin
				carry_d   = rd_data_q;
				i_d       = lo_q;
				swapped_d = 1'b0;
				rd_addr   = lo_q + IDX_W'(1);
				state_d   = ST_F_STEP;
			end
			ST_F_STEP: begin
				wr_en     = 1'b1;
				wr_addr   = i_q;
				wr_data   = cmp_res.lo_val;
				carry_d   = cmp_res.hi_val;
				edge_d    = cmp_res.lo_val;
				swapped_d = swapped_q | cmp_res.gt;
				i_next    = i_q + IDX_W'(1);
				i_d       = i_next;
				if (i_next == hi_q) begin
					state_d = ST_F_END;
				end else begin
					rd_addr = i_next + IDX_W'(1);
				end
			end
			ST_F_END: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = carry_q;
				hi_new  = hi_q - IDX_W'(1);
				k_d     = '0;
				if (!swapped_q) begin
					state_d = ST_E_RD;
				end else begin
					hi_d = hi_new;
					if (hi_new == lo_q) begin
						state_d = ST_E_RD;
					end else begin
						carry_d   = edge_q;
						i_d       = hi_new;
						swapped_d = 1'b0;
						rd_addr   = hi_new - IDX_W'(1);
						state_d   = ST_B_STEP;
					end
				end
			end
			ST_B_STEP: begin
				wr_en     = 1'b1;
				wr_addr   = i_q;
				wr_data   = cmp_res.hi_val;
				carry_d   = cmp_res.lo_val;
				edge_d    = cmp_res.hi_val;
				swapped_d = swapped_q | cmp_res.gt;
				i_next    = i_q - IDX_W'(1);
				i_d       = i_next;
				if (i_next == lo_q) begin
					state_d = ST_B_END;
				end else begin
					rd_addr = i_next - IDX_W'(1);
				end
			end
			ST_B_END: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = carry_q;
				lo_new  = lo_q + IDX_W'(1);
				lo_d    = lo_new;
				k_d     = '0;
				if (!swapped_q || lo_new >= hi_q) begin
					state_d = ST_E_RD;
				end else begin
					carry_d   = edge_q;
					i_d       = lo_new;
					swapped_d = 1'b0;
					rd_addr   = lo_new + IDX_W'(1);
					state_d   = ST_F_STEP;
				end
			end
			ST_E_RD: begin
				rd_addr = k_q;
				state_d = ST_E_LD;
			end
			ST_E_LD: begin
				out_d.sorted_value  = rd_data_q;
				out_d.final_result  = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
				out_d.overflow_seen = ovf_q;
				out_valid_d         = 1'b1;
				state_d             = ST_E_WAIT;
			end
			ST_E_WAIT: begin
				if (!result_stall) begin
					out_valid_d = 1'b0;
					if (out_q.final_result) begin
						// Set delivered: drop the fill count and overflow mark.
						count_d = '0;
						ovf_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + IDX_W'(1);
						rd_addr = k_q + IDX_W'(1);
						state_d = ST_E_LD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		i_q       <= i_d;
		k_q       <= k_d;
		carry_q   <= carry_d;
		edge_q    <= edge_d;
		swapped_q <= swapped_d;
		out_q     <= out_d;
	end

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= store_q[rd_addr];
	end

endmodule

### design/css_checker.sv
// Port-level checker for the cocktail shaker sorter, bound to the top level.
// Depends on css_pkg and cocktail_shaker_sorter.
module css_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input css_pkg::css_item_t   item,
	input logic                 result_valid,
	input logic                 result_stall,
	input css_pkg::css_result_t result
);
	import css_pkg::*;

	// No new item is taken while results of a set are still going out.
	a_no_take_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item taken while a result is pending");

	// A final item closes the set: the input must stall next.
	a_stall_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.final_element) |=> item_stall)
		else $error("input not stalled after the final item");

	// Nothing follows the last result of a set straight away.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.final_result) |=> !result_valid)
		else $error("result presented straight after the last one");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed");

endmodule

bind cocktail_shaker_sorter css_checker u_css_checker (.*);
